@@ hw/rtl/swfd_pkg.sv @@
// Shared types, constants and CRC function for the sensor word frame decoder.
package swfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // byte phase within a word
    localparam logic [1:0] PH_MSB = 2'd0;
    localparam logic [1:0] PH_LSB = 2'd1;
    localparam logic [1:0] PH_CRC = 2'd2;

    // word kinds, in frame order
    localparam logic [1:0] KIND_CO2  = 2'd0;
    localparam logic [1:0] KIND_TEMP = 2'd1;
    localparam logic [1:0] KIND_RH   = 2'd2;

    localparam int          COEF_W     = 13;
    localparam int          PROD_W     = 29;
    localparam logic [12:0] TEMP_MUL   = 13'd4375;
    localparam int          TEMP_SHIFT = 14;
    localparam int          TEMP_W     = 15;
    localparam logic [16:0] TEMP_OFS   = 17'd4500;
    localparam logic [12:0] RH_MUL     = 13'd625;
    localparam int          RH_SHIFT   = 12;
    localparam int          RH_W       = 14;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] raw;
        logic        crc_ok;
        logic        last;
    } t_word;

    // MSB-first CRC-8, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/swfd_ifs.sv @@
// Valid/ready channel interfaces for the frame byte input and the word result output.
interface swfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface swfd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         word_kind;
    logic [15:0]        raw_word;
    logic signed [16:0] scaled_value;
    logic               crc_ok;
    logic               frame_last;

    modport source (output valid, output word_kind, output raw_word, output scaled_value,
                    output crc_ok, output frame_last, input ready);
    modport sink   (input valid, input word_kind, input raw_word, input scaled_value,
                    input crc_ok, input frame_last, output ready);
endinterface

@@ hw/rtl/swfd_front.sv @@
// Front end: tracks frame position, runs the CRC and assembles words from bytes.
module swfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    swfd_in_if.sink             i_in,
    input  logic                i_room,
    output logic                o_push,
    output swfd_pkg::t_word     o_word
);

    logic [1:0]  r_phase, n_phase;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_word, n_word;
    logic [1:0]  phase, kind;
    logic        accept;

    assign i_in.ready = i_room;
    assign accept     = i_in.valid && i_room;

    always_comb begin
        phase   = i_in.frame_start ? swfd_pkg::PH_MSB : r_phase;
        kind    = i_in.frame_start ? swfd_pkg::KIND_CO2 : r_kind;
        n_phase = r_phase;
        n_kind  = r_kind;
        n_crc   = r_crc;
        n_word  = r_word;
        o_push  = 1'b0;
        o_word.kind   = kind;
        o_word.raw    = r_word;
        o_word.crc_ok = (r_crc == i_in.rx_byte);
        o_word.last   = (kind == swfd_pkg::KIND_RH);
        if (accept) begin
            unique case (phase)
                swfd_pkg::PH_MSB: begin
                    n_crc   = swfd_pkg::crc8_update(swfd_pkg::CRC_INIT, i_in.rx_byte);
                    n_word  = {i_in.rx_byte, 8'h00};
                    n_phase = swfd_pkg::PH_LSB;
                    n_kind  = kind;
                end
                swfd_pkg::PH_LSB: begin
                    n_crc   = swfd_pkg::crc8_update(r_crc, i_in.rx_byte);
                    n_word  = {r_word[15:8], i_in.rx_byte};
                    n_phase = swfd_pkg::PH_CRC;
                    n_kind  = kind;
                end
                swfd_pkg::PH_CRC: begin
                    o_push  = 1'b1;
                    n_crc   = swfd_pkg::CRC_INIT;
                    n_phase = swfd_pkg::PH_MSB;
                    // past the third word the next byte opens a new frame
                    n_kind  = (kind == swfd_pkg::KIND_RH) ? swfd_pkg::KIND_CO2 : kind + 2'd1;
                end
                default: begin
                    n_phase = swfd_pkg::PH_MSB;
                    n_kind  = swfd_pkg::KIND_CO2;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= swfd_pkg::PH_MSB;
            r_kind  <= swfd_pkg::KIND_CO2;
            r_crc   <= swfd_pkg::CRC_INIT;
            r_word  <= '0;
        end else begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_crc   <= n_crc;
            r_word  <= n_word;
        end
    end

endmodule

@@ hw/rtl/swfd_queue.sv @@
// Small word queue between the front end and the scaling back end.
module swfd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  swfd_pkg::t_word i_word,
    output logic            o_room,
    output logic            o_valid,
    output swfd_pkg::t_word o_word,
    input  logic            i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    swfd_pkg::t_word r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_room  = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_room;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ hw/rtl/swfd_back.sv @@
// Back end: scales the raw word by kind and holds the result in the output register.
module swfd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  swfd_pkg::t_word i_word,
    output logic            o_pop,
    swfd_out_if.source      o_out
);

    logic                        r_valid;
    swfd_pkg::t_word             r_word;
    logic signed [16:0]          r_scaled, n_scaled;
    logic [swfd_pkg::COEF_W-1:0] coef;
    logic [swfd_pkg::PROD_W-1:0] prod;

    assign o_pop = i_valid && (!r_valid || o_out.ready);

    always_comb begin
        coef = (i_word.kind == swfd_pkg::KIND_TEMP) ? swfd_pkg::TEMP_MUL : swfd_pkg::RH_MUL;
        prod = swfd_pkg::PROD_W'(coef) * swfd_pkg::PROD_W'(i_word.raw);
        unique case (i_word.kind)
            swfd_pkg::KIND_TEMP: begin
                n_scaled = $signed({2'b00, prod[swfd_pkg::TEMP_SHIFT +: swfd_pkg::TEMP_W]}
                                   - swfd_pkg::TEMP_OFS);
            end
            swfd_pkg::KIND_RH: begin
                n_scaled = $signed({3'b000, prod[swfd_pkg::RH_SHIFT +: swfd_pkg::RH_W]});
            end
            default: begin
                n_scaled = $signed({1'b0, i_word.raw});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word   <= i_word;
            r_scaled <= n_scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.word_kind    = r_word.kind;
    assign o_out.raw_word     = r_word.raw;
    assign o_out.scaled_value = r_scaled;
    assign o_out.crc_ok       = r_word.crc_ok;
    assign o_out.frame_last   = r_word.last;

endmodule

@@ hw/rtl/sensor_word_frame_decoder_top.sv @@
// Sensor word frame decoder: CRC-checked word extraction and scaling from a 9-byte frame.
//
// Input channel i_in carries one frame byte per item (rx_byte) with frame_start marking
// the first byte of a frame. Each frame is CO2, temperature, humidity words, each sent as
// MSB, LSB, CRC-8 (poly 0x31, init 0xFF). Output channel o_out gives one item per CRC
// byte: kind, raw word, scaled value (ppm, centidegrees C, centipercent RH), CRC verdict,
// and frame_last on the humidity word. MSB and LSB bytes give no result.
// Throughput: one byte per cycle, sustained while o_out is ready. CRC runs a byte per
// cycle in the front end; scaling is one constant multiply, plus an offset for
// temperature, in the back end, while CO2 words pass through unscaled.
// A queue of QUEUE_DEPTH words sits between front and back end. When o_out stalls the
// output register holds its item, the queue fills, and once it is full i_in.ready drops
// until the receiver takes an item. Without frame_start, a tenth byte starts a new frame.
// Reset (synchronous, active low) returns to the start of a frame with the CRC at 0xFF
// and empties the queue and the output register.
module sensor_word_frame_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swfd_in_if.sink     i_in,
    swfd_out_if.source  o_out
);

    logic            push, room, q_valid, pop;
    swfd_pkg::t_word front_word, head_word;

    swfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push),
        .o_word  (front_word)
    );

    swfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (front_word),
        .o_room  (room),
        .o_valid (q_valid),
        .o_word  (head_word),
        .i_pop   (pop)
    );

    swfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_word  (head_word),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

@@ hw/rtl/swfd_checker.sv @@
// Port-level checks on the decoder's result channel, bound to the top level.
module swfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_word_kind,
    input logic [15:0] i_raw_word,
    input logic [16:0] i_scaled_value,
    input logic        i_frame_last
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_raw_word))
        else $error("stalled result dropped or changed");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_last |-> i_word_kind == swfd_pkg::KIND_RH)
        else $error("frame_last on a word other than humidity");

    a_co2_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_word_kind == swfd_pkg::KIND_CO2 |-> i_scaled_value == {1'b0, i_raw_word})
        else $error("CO2 scaled value differs from raw word");

endmodule

bind sensor_word_frame_decoder_top swfd_checker u_swfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_word_kind    (o_out.word_kind),
    .i_raw_word     (o_out.raw_word),
    .i_scaled_value (o_out.scaled_value),
    .i_frame_last   (o_out.frame_last)
);
